FILE: rtl/core/arnp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arnp_pkg: shared types and constants of the auto radix number parser
// Holds the radix codes, the prefix parse phases, the operation that passes
// from the classifier to the accumulator, and the digit decoder.
// ----------------------------------------------------------------------------
package arnp_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_F   = 8'h46;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [4:0] DIGIT_BAD = 5'd16;

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_OCT = 2'd1,
    RADIX_HEX = 2'd2
  } radix_t;

  typedef enum logic [2:0] {
    PH_START    = 3'd0,
    PH_ZERO     = 3'd1,
    PH_DOLLAR   = 3'd2,
    PH_DOLLAR_Z = 3'd3,
    PH_DIGITS   = 3'd4,
    PH_STOPPED  = 3'd5
  } phase_t;

  typedef struct packed {
    logic       start;
    logic       take;
    logic [3:0] digit;
    radix_t     radix;
    logic       last;
  } op_t;

  function automatic logic [4:0] digit_of(input logic [7:0] c, input radix_t r);
    logic [7:0] t;
    logic [4:0] d;
    begin
      t = 8'h00;
      d = DIGIT_BAD;
      if (c inside {[CH_ZERO:CH_NINE]}) begin
        t = c - CH_ZERO;
        if (r != RADIX_OCT || c <= CH_SEVEN) begin
          d = t[4:0];
        end
      end else if (r == RADIX_HEX && c inside {[CH_UP_A:CH_UP_F]}) begin
        t = c - CH_UP_A + 8'd10;
        d = t[4:0];
      end else if (r == RADIX_HEX && c inside {[CH_LOW_A:CH_LOW_F]}) begin
        t = c - CH_LOW_A + 8'd10;
        d = t[4:0];
      end
      return d;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/arnp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arnp_front: prefix classifier
// Tracks the prefix of the current string and turns each character into an
// accumulator operation with its radix and digit value.
// ----------------------------------------------------------------------------
module arnp_front
  import arnp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       fire,
  input  wire logic [7:0] ch,
  input  wire logic       last,
  output op_t             op
);

  phase_t phase_r, phase_nxt;
  radix_t radix_r, radix_nxt;
  radix_t eff_radix;
  logic [4:0] dig;
  logic valid_dig;
  logic is_dollar, is_zero, is_x;

  assign is_dollar = (ch == CH_DOLLAR);
  assign is_zero   = (ch == CH_ZERO);
  assign is_x      = (ch == CH_LOW_X);

  always_comb begin
    eff_radix = radix_r;
    case (phase_r)
      PH_START: begin
        if (is_dollar) begin
          eff_radix = RADIX_HEX;
        end else if (is_zero) begin
          eff_radix = RADIX_OCT;
        end else begin
          eff_radix = RADIX_DEC;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          eff_radix = RADIX_HEX;
        end
      end
      default: eff_radix = radix_r;
    endcase
  end

  assign dig       = digit_of(ch, eff_radix);
  assign valid_dig = (dig != DIGIT_BAD);

  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_START: begin
        if (is_dollar) begin
          phase_nxt = PH_DOLLAR;
        end else if (is_zero) begin
          phase_nxt = PH_ZERO;
        end else begin
          phase_nxt = valid_dig ? PH_DIGITS : PH_STOPPED;
        end
      end
      PH_ZERO, PH_DOLLAR_Z: begin
        if (is_x) begin
          phase_nxt = PH_DIGITS;
        end else begin
          phase_nxt = valid_dig ? PH_DIGITS : PH_STOPPED;
        end
      end
      PH_DOLLAR: begin
        if (is_zero) begin
          phase_nxt = PH_DOLLAR_Z;
        end else begin
          phase_nxt = valid_dig ? PH_DIGITS : PH_STOPPED;
        end
      end
      PH_DIGITS: phase_nxt = valid_dig ? PH_DIGITS : PH_STOPPED;
      default:   phase_nxt = PH_STOPPED;
    endcase
    if (last) begin
      phase_nxt = PH_START;
    end
  end

  assign radix_nxt = last ? RADIX_DEC : eff_radix;

  always_comb begin
    op.start = (phase_r == PH_START);
    op.digit = dig[3:0];
    op.radix = eff_radix;
    op.last  = last;
    case (phase_r)
      PH_START:    op.take = valid_dig && !is_dollar && !is_zero;
      PH_ZERO:     op.take = valid_dig && !is_x;
      PH_DOLLAR:   op.take = valid_dig && !is_zero;
      PH_DOLLAR_Z: op.take = valid_dig && !is_x;
      PH_DIGITS:   op.take = valid_dig;
      default:     op.take = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      radix_r <= RADIX_DEC;
    end else if (fire) begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/arnp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arnp_queue: operation queue
// A short first-in first-out buffer of accumulator operations that lets the
// classifier and the accumulator stall independently.
// ----------------------------------------------------------------------------
module arnp_queue
  import arnp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  op_t       push_op,
  output logic      full,
  input  wire logic pop,
  output logic      not_empty,
  output op_t       head_op
);

  localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(QUEUE_DEPTH - 1);

  op_t             mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == DEPTH_C);
  assign not_empty = (cnt_r != '0);
  assign head_op   = mem_r[rd_r];

  assign wr_nxt = (wr_r == LAST_P) ? '0 : wr_r + 1'b1;
  assign rd_nxt = (rd_r == LAST_P) ? '0 : rd_r + 1'b1;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_nxt;
      end
      if (pop) begin
        rd_r <= rd_nxt;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/arnp_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// arnp_back: digit accumulator
// Applies queued operations to the 32-bit accumulator and holds the finished
// value and radix in an output register until the transaction completes.
// ----------------------------------------------------------------------------
module arnp_back
  import arnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        op_valid,
  input  op_t              op,
  output logic             op_pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_value,
  output logic [1:0]       out_radix
);

  logic [31:0] accum_r, accum_nxt;
  logic [31:0] base;
  logic [31:0] d_ext;
  logic        out_valid_r, out_valid_nxt;
  logic [31:0] out_value_r;
  radix_t      out_radix_r;

  assign base  = op.start ? 32'd0 : accum_r;
  assign d_ext = {28'd0, op.digit};

  always_comb begin
    accum_nxt = base;
    if (op.take) begin
      case (op.radix)
        RADIX_HEX: accum_nxt = {base[27:0], op.digit};
        RADIX_OCT: accum_nxt = {base[28:0], op.digit[2:0]};
        default:   accum_nxt = {base[28:0], 3'b000} + {base[30:0], 1'b0} + d_ext;
      endcase
    end
  end

  assign op_pop = op_valid && (!op.last || !out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (op_pop && op.last) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r     <= 32'd0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (op_pop) begin
        accum_r <= op.last ? 32'd0 : accum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && op.last) begin
      out_value_r <= accum_nxt;
      out_radix_r <= op.radix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_radix = out_radix_r;

endmodule
`default_nettype wire

FILE: rtl/core/auto_radix_number_parser_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// auto_radix_number_parser_core: ASCII integer parser with radix detection
// Parses one numeric string per result, choosing decimal, octal or
// hexadecimal from the prefix.
// ----------------------------------------------------------------------------
// The block takes one character per clock cycle while the queue is not
// full and gives one transaction with the 32-bit value and the radix for
// each character marked last. A classifier follows the prefix and decodes
// each character into a digit operation in the cycle it is taken; a
// two-entry queue carries the operation to the accumulator, which applies
// one shift or multiply-by-ten add per cycle unless a last operation waits
// on an unread result. The result is held in an output register until the
// transaction completes, and characters flow on until the queue is full.
// ----------------------------------------------------------------------------
module auto_radix_number_parser_core
  import arnp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_value,
  output logic [1:0]       out_radix
);

  logic fire;
  logic q_full, q_not_empty, q_pop;
  op_t  front_op, head_op;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;

  arnp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .ch    (in_ch),
    .last  (in_last),
    .op    (front_op)
  );

  arnp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_op   (front_op),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head_op   (head_op)
  );

  arnp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (q_not_empty),
    .op        (head_op),
    .op_pop    (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .out_radix (out_radix)
  );

endmodule
`default_nettype wire
